FILE: rtl/hpt_pkg.sv
// shared types and constants for the homogeneous point transform
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hpt_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MAT_DEPTH      = 16;
  localparam int COEF_AW        = 4;
  localparam int DIGIT_W        = 16;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_XFORM = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               en;
    logic [COEF_AW-1:0] addr;
  } rd_req_t;

endpackage

`default_nettype wire

FILE: rtl/hpt_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module hpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hpt_dot.sv
// row dot products of the matrix against (x, y, z, 1), one coefficient read per term
// depends on hpt_pkg; coefficients come from the matrix ram in the cycle after a read
`timescale 1ns / 1ps
`default_nettype none

module hpt_dot #(
  parameter int WORD_WIDTH = hpt_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [WORD_WIDTH-1:0]   px,
  input  logic [WORD_WIDTH-1:0]   py,
  input  logic [WORD_WIDTH-1:0]   pz,
  output hpt_pkg::rd_req_t        rd,
  input  logic [WORD_WIDTH-1:0]   coef,
  output logic                    done,
  output logic [4*WORD_WIDTH-1:0] t_vec
);

  localparam int W     = WORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int DW    = hpt_pkg::DIGIT_W;
  localparam int ACC_W = W + F;
  localparam int ND    = (W + DW - 1) / DW;
  localparam int BP    = ND * DW;
  localparam int PPW   = W + DW + 1;
  localparam int XW    = (PPW > ACC_W) ? PPW : ACC_W;
  localparam int DCW   = (ND > 1) ? $clog2(ND) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_TRANS
  } state_t;

  state_t           state;
  logic [1:0]       row;
  logic [1:0]       term;
  logic [DCW-1:0]   digit;
  logic [ACC_W-1:0] acc;

  logic [W-1:0]          b_sel;
  logic signed [BP-1:0]  b_pad;
  logic [DW-1:0]         dig;
  logic signed [DW:0]    dig_ext;
  logic signed [PPW-1:0] pp;
  logic signed [XW-1:0]  pp_x;
  logic [XW-1:0]         pp_sh;
  logic [ACC_W-1:0]      acc_mul;
  logic [ACC_W-1:0]      acc_tr;

  always_comb begin
    case (term)
      2'd0:    b_sel = px;
      2'd1:    b_sel = py;
      default: b_sel = pz;
    endcase
  end

  // digits of the point coordinate, low ones unsigned, the top one signed
  assign b_pad   = BP'($signed(b_sel));
  assign dig     = b_pad[digit*DW +: DW];
  assign dig_ext = (digit == DCW'(ND - 1)) ? $signed({dig[DW-1], dig})
                                           : $signed({1'b0, dig});
  assign pp      = $signed(coef) * dig_ext;
  assign pp_x    = XW'(pp);
  assign pp_sh   = pp_x << (digit * DW);
  assign acc_mul = acc + pp_sh[ACC_W-1:0];
  assign acc_tr  = acc + {coef, {F{1'b0}}};

  assign rd.en   = (state == S_READ);
  assign rd.addr = {term, row};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      row   <= '0;
      term  <= '0;
      digit <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            row   <= '0;
            term  <= '0;
            acc   <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          digit <= '0;
          state <= (term == 2'd3) ? S_TRANS : S_MUL;
        end
        S_MUL: begin
          acc <= acc_mul;
          if (digit == DCW'(ND - 1)) begin
            term  <= term + 2'd1;
            state <= S_READ;
          end else begin
            digit <= digit + DCW'(1);
          end
        end
        S_TRANS: begin
          t_vec[row*W +: W] <= acc_tr[ACC_W-1:F];
          acc               <= '0;
          term              <= '0;
          if (row == 2'd3) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            row   <= row + 2'd1;
            state <= S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hpt_div.sv
// perspective divide: three restoring dividers by w sharing one bit counter
// depends on hpt_pkg for parameter defaults
`timescale 1ns / 1ps
`default_nettype none

module hpt_div #(
  parameter int WORD_WIDTH = hpt_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [4*WORD_WIDTH-1:0] t_vec,
  output logic                    done,
  output logic [3*WORD_WIDTH-1:0] q_vec,
  output logic                    w_zero
);

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int CW = $clog2(W);
  localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIN
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic [W-1:0]  dmag_r;
  logic          wz;

  logic [W-1:0] rem  [3];
  logic [W-1:0] low  [3];
  logic [W-1:0] quo  [3];
  logic         ovf  [3];
  logic         neg  [3];

  logic [W-1:0] d;
  logic [W-1:0] dmag;
  logic [W-1:0] nmag     [3];
  logic [W-1:0] hi_init  [3];
  logic [W-1:0] low_init [3];
  logic         ovf_init [3];
  logic [W:0]   rem2     [3];
  logic         ge       [3];
  logic [W:0]   diff     [3];
  logic [W-1:0] rem_next [3];
  logic [W-1:0] sat      [3];

  assign d    = t_vec[3*W +: W];
  assign dmag = d[W-1] ? (~d + W'(1)) : d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nmag[k]     = t_vec[k*W + W - 1] ? (~t_vec[k*W +: W] + W'(1)) : t_vec[k*W +: W];
      hi_init[k]  = nmag[k] >> (W - F);
      low_init[k] = nmag[k] << F;
      ovf_init[k] = (hi_init[k] >= dmag);
      rem2[k]     = {rem[k], low[k][W-1]};
      ge[k]       = (rem2[k] >= {1'b0, dmag_r});
      diff[k]     = rem2[k] - {1'b0, dmag_r};
      rem_next[k] = ge[k] ? diff[k][W-1:0] : rem2[k][W-1:0];
      if (neg[k]) begin
        sat[k] = (ovf[k] || (quo[k][W-1] && (|quo[k][W-2:0]))) ? MINN
                                                              : (~quo[k] + W'(1));
      end else begin
        sat[k] = (ovf[k] || quo[k][W-1]) ? MAXP : quo[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            dmag_r <= dmag;
            wz     <= (d == '0);
            cnt    <= '0;
            for (int k = 0; k < 3; k++) begin
              rem[k] <= hi_init[k];
              low[k] <= low_init[k];
              quo[k] <= '0;
              ovf[k] <= ovf_init[k];
              neg[k] <= t_vec[k*W + W - 1] ^ d[W-1];
            end
            state <= (d == '0) ? D_FIN : D_RUN;
          end
        end
        D_RUN: begin
          for (int k = 0; k < 3; k++) begin
            rem[k] <= rem_next[k];
            low[k] <= low[k] << 1;
            quo[k] <= {quo[k][W-2:0], ge[k]};
          end
          if (cnt == CW'(W - 1)) begin
            state <= D_FIN;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        D_FIN: begin
          for (int k = 0; k < 3; k++) begin
            q_vec[k*W +: W] <= wz ? '0 : sat[k];
          end
          w_zero <= wz;
          done   <= 1'b1;
          state  <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/homogeneous_point_transform_unit.sv
// top level of the homogeneous point transform: stream ports, matrix ram, sequencing
// depends on hpt_pkg, hpt_ram, hpt_dot and hpt_div
//
// usage:
//   s_* carries words in: s_tuser selects the command. a load word (s_tuser = 0)
//   writes coef_value into matrix position coef_index and gives no output word.
//   a transform word (s_tuser = 1) brings a point (x, y, z) with implied w = 1.
//   m_* returns one word per transform: the projected x, y, z in q16.16 and, in
//   m_tuser, a flag set when w was zero (coordinates then zero).
//   a load is written on accept and the unit stays idle. a transform runs the
//   matrix ram read and the digit multiplier of the shared multiply-accumulate,
//   with ND = ceil(W/16) digits where W is WORD_WIDTH, for the row dot products,
//   then the bit-serial divide by w. a zero w skips the divide.
//   one transform is in work at a time; s_tready is high only while idle.
//   a finished result sits in the output register, so a stalled receiver does not
//   hold off the next word; a second result waits until the register frees.
//   reset empties the output register and marks every coefficient as zero.
`timescale 1ns / 1ps
`default_nettype none

module homogeneous_point_transform_unit #(
  parameter int WORD_WIDTH = hpt_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = hpt_pkg::FRAC_BITS_DEF,
  localparam int IN_DW  = ((hpt_pkg::COEF_AW + 4*WORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((3*WORD_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_DW-1:0]  s_tdata,   // coef_index, coef_value, in_x, in_y, in_z
  input  logic              s_tuser,   // command
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_DW-1:0] m_tdata,   // out_x, out_y, out_z
  output logic              m_tuser    // w_zero
);

  localparam int W  = WORD_WIDTH;
  localparam int AW = hpt_pkg::COEF_AW;

  typedef enum logic [1:0] {
    T_IDLE,
    T_DOT,
    T_DIV,
    T_HOLD
  } state_t;

  state_t state;
  logic   dot_start;
  logic   div_start;

  logic [AW-1:0] coef_index;
  logic [W-1:0]  coef_value;
  logic          s_accept;
  logic          load_we;
  logic          xform;
  logic          out_free;
  logic          out_load;

  logic [W-1:0]            px;
  logic [W-1:0]            py;
  logic [W-1:0]            pz;
  logic [hpt_pkg::MAT_DEPTH-1:0] coef_vld;
  logic                    rd_vld;
  logic [W-1:0]            rdata;
  logic [W-1:0]            coef;
  hpt_pkg::rd_req_t        rd;
  logic                    dot_done;
  logic [4*W-1:0]          t_vec;
  logic                    div_done;
  logic [3*W-1:0]          q_vec;
  logic                    w_zero;

  assign coef_index = s_tdata[AW-1:0];
  assign coef_value = s_tdata[AW +: W];
  assign s_tready   = (state == T_IDLE);
  assign s_accept   = s_tvalid && s_tready;
  assign load_we    = s_accept && (hpt_pkg::cmd_t'(s_tuser) == hpt_pkg::CMD_LOAD);
  assign xform      = s_accept && (hpt_pkg::cmd_t'(s_tuser) == hpt_pkg::CMD_XFORM);
  assign out_free   = !m_tvalid || m_tready;
  assign out_load   = out_free && (((state == T_DIV) && div_done) || (state == T_HOLD));
  assign coef       = rd_vld ? rdata : '0;

  hpt_ram #(
    .WIDTH (W),
    .DEPTH (hpt_pkg::MAT_DEPTH)
  ) u_mat_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (coef_index),
    .wdata (coef_value),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (rdata)
  );

  // unwritten coefficients read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
      rd_vld   <= 1'b0;
    end else begin
      if (load_we) begin
        coef_vld[coef_index] <= 1'b1;
      end
      if (rd.en) begin
        rd_vld <= coef_vld[rd.addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xform) begin
      px <= s_tdata[AW + W +: W];
      py <= s_tdata[AW + 2*W +: W];
      pz <= s_tdata[AW + 3*W +: W];
    end
  end

  hpt_dot #(
    .WORD_WIDTH (W),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dot (
    .clk   (clk),
    .rst   (rst),
    .start (dot_start),
    .px    (px),
    .py    (py),
    .pz    (pz),
    .rd    (rd),
    .coef  (coef),
    .done  (dot_done),
    .t_vec (t_vec)
  );

  hpt_div #(
    .WORD_WIDTH (W),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .t_vec  (t_vec),
    .done   (div_done),
    .q_vec  (q_vec),
    .w_zero (w_zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      dot_start <= 1'b0;
      div_start <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      dot_start <= 1'b0;
      div_start <= 1'b0;
      m_tvalid  <= out_load || (m_tvalid && !m_tready);
      case (state)
        T_IDLE: begin
          if (xform) begin
            dot_start <= 1'b1;
            state     <= T_DOT;
          end
        end
        T_DOT: begin
          if (dot_done) begin
            div_start <= 1'b1;
            state     <= T_DIV;
          end
        end
        T_DIV: begin
          if (div_done) begin
            if (out_free) begin
              m_tdata  <= OUT_DW'(q_vec);
              m_tuser  <= w_zero;
              state    <= T_IDLE;
            end else begin
              state <= T_HOLD;
            end
          end
        end
        T_HOLD: begin
          if (out_free) begin
            m_tdata  <= OUT_DW'(q_vec);
            m_tuser  <= w_zero;
            state    <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hpt_chk.sv
// port-level checks for the homogeneous point transform, bound to the top level
// depends on hpt_pkg and homogeneous_point_transform_unit
`timescale 1ns / 1ps
`default_nettype none

module hpt_chk #(
  parameter int WORD_WIDTH = hpt_pkg::WORD_WIDTH_DEF,
  localparam int OUT_DW = ((3*WORD_WIDTH + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              s_tuser,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_DW-1:0] m_tdata,
  input logic              m_tuser
);

  // stalled output word holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // a transform keeps the input closed on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (hpt_pkg::cmd_t'(s_tuser) == hpt_pkg::CMD_XFORM) |=> !s_tready)
    else $error("input open right after a transform");

  // zero w gives zero coordinates
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == '0))
    else $error("w zero flag with nonzero coordinates");

  // a new result only comes out of the busy phase
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("output word raised while idle");

endmodule

bind homogeneous_point_transform_unit hpt_chk #(
  .WORD_WIDTH (WORD_WIDTH)
) u_hpt_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
